>>> sv/bkcf_pkg.sv
// Shared types, constants and coefficient table for the Battin K continued-fraction block.
package bkcf_pkg;

  localparam int TABLE_LEN = 21;

  localparam logic signed [31:0] W_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] W_MIN = 32'sh8000_0000;

  localparam logic [1:0] REG_TOLERANCE = 2'd0;
  localparam logic [1:0] REG_MAX_TERMS = 2'd1;

  localparam logic [15:0] TOLERANCE_RESET = 16'd268;
  localparam logic [4:0]  MAX_TERMS_RESET = 5'd20;

  localparam logic [63:0] COEF_NUM [TABLE_LEN] = '{
    64'd1, 64'd4, 64'd8, 64'd2, 64'd22, 64'd208, 64'd340, 64'd418, 64'd598, 64'd700,
    64'd928, 64'd1054, 64'd1330, 64'd1480, 64'd1804, 64'd1978, 64'd2350, 64'd2548,
    64'd2968, 64'd3190, 64'd3658
  };

  localparam logic [63:0] COEF_DEN [TABLE_LEN] = '{
    64'd3, 64'd27, 64'd27, 64'd9, 64'd81, 64'd891, 64'd1287, 64'd1755, 64'd2295,
    64'd2907, 64'd3591, 64'd4347, 64'd5175, 64'd6075, 64'd7047, 64'd8091, 64'd9207,
    64'd10395, 64'd11655, 64'd12987, 64'd14391
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_CV,
    ST_WAIT_CV,
    ST_MUL_DEL,
    ST_WAIT_DEL,
    ST_CHK_DEN,
    ST_WAIT_RCP,
    ST_SUB_ONE,
    ST_MUL_TERM,
    ST_WAIT_TERM,
    ST_ACCUM,
    ST_DONE
  } bkcf_state_t;

endpackage

>>> sv/bkcf_qmul.sv
// Two-stage fixed-point multiplier with round-half-away and saturation.
module bkcf_qmul
  import bkcf_pkg::*;
#(
  parameter int FRAC_BITS = 28
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic               done,
  output logic signed [31:0] q
);

  localparam logic [63:0] RND = 64'd1 << (FRAC_BITS - 1);

  logic [31:0] mag_a;
  logic [31:0] mag_b;
  logic [63:0] prod;
  logic        neg;
  logic        stage1;
  logic [63:0] rounded;
  logic signed [31:0] q_next;

  assign mag_a = a[31] ? 32'(-a) : 32'(a);
  assign mag_b = b[31] ? 32'(-b) : 32'(b);

  assign rounded = (prod + RND) >> FRAC_BITS;

  always_comb begin
    if (neg) begin
      if (rounded > 64'h0000_0000_8000_0000) q_next = W_MIN;
      else q_next = 32'(-rounded[31:0]);
    end else begin
      if (rounded > 64'(W_MAX)) q_next = W_MAX;
      else q_next = rounded[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      done   <= 1'b0;
    end else begin
      stage1 <= start;
      done   <= stage1;
    end
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mag_a) * 64'(mag_b);
    neg  <= a[31] ^ b[31];
    q    <= q_next;
  end

endmodule

>>> sv/bkcf_recip.sv
// Bit-serial restoring reciprocal: 2^(2*FRAC_BITS) / x, truncated and saturated.
module bkcf_recip
  import bkcf_pkg::*;
#(
  parameter int FRAC_BITS = 28
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] x,
  output logic               done,
  output logic signed [31:0] q
);

  localparam int CNT_W = $clog2(2 * FRAC_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(2 * FRAC_BITS);

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [31:0]      m;
  logic [31:0]      r;
  logic [31:0]      quo;
  logic             big;
  logic             neg;

  logic [32:0]      r_sh;
  logic             ge;
  logic [31:0]      r_next;
  logic [31:0]      quo_next;
  logic             big_next;
  logic signed [31:0] q_final;

  assign r_sh     = {r, (cnt == CNT_TOP)};
  assign ge       = r_sh >= {1'b0, m};
  assign r_next   = ge ? 32'(r_sh - {1'b0, m}) : r_sh[31:0];
  assign quo_next = {quo[30:0], ge};
  assign big_next = big | quo[31] | quo[30];

  always_comb begin
    if (neg) q_final = big_next ? W_MIN : 32'(-quo_next);
    else q_final = big_next ? W_MAX : quo_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && cnt == '0) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      m   <= x[31] ? 32'(-x) : 32'(x);
      neg <= x[31];
      r   <= '0;
      quo <= '0;
      big <= 1'b0;
      cnt <= CNT_TOP;
    end else if (running) begin
      r   <= r_next;
      quo <= quo_next;
      big <= big_next;
      cnt <= cnt - 1'b1;
      if (cnt == '0) q <= q_final;
    end
  end

endmodule

>>> sv/battin_k_continued_fraction.sv
// Top level: sequencer and registers for the Battin K continued-fraction evaluator.
//
// Usage: present arg_v with start high while busy is low; that edge accepts the
// transaction and busy rises in the next cycle. The block then evaluates the
// series term by term on one shared multiplier and one bit-serial reciprocal
// unit. Each term runs three multiplies and one reciprocal, plus bookkeeping;
// the reciprocal loop dominates. A new transaction is accepted only once busy
// is low again, after done; a zero denominator ends the transaction before
// its reciprocal is started.
// The result (k_value, terms_used, div_fault) is valid for exactly one cycle
// while done is high; busy drops in the cycle after done. The receiver cannot
// stall, so results must be taken when done is high.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 tolerance,
// 1 max_terms) at the clock edge; write only while busy is low. Unknown indexes
// are ignored.
// Reset (rst, synchronous): returns to idle, tolerance = 268, max_terms = 20.
module battin_k_continued_fraction
  import bkcf_pkg::*;
#(
  parameter int NUM_TERMS = 20,
  parameter int FRAC_BITS = 28
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] arg_v,
  output logic               done,
  output logic signed [31:0] k_value,
  output logic [4:0]         terms_used,
  output logic               div_fault,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam logic signed [31:0] ONE =
    (FRAC_BITS >= 31) ? W_MAX : 32'(64'd1 << FRAC_BITS);
  localparam logic [4:0] LIM_MAX = 5'(NUM_TERMS);

  function automatic logic signed [31:0] sat33(input logic signed [32:0] s);
    logic signed [31:0] res;
    if (s > 33'sh0_7FFF_FFFF) res = W_MAX;
    else if (s < -33'sh0_8000_0000) res = W_MIN;
    else res = s[31:0];
    return res;
  endfunction

  logic signed [31:0] coef_rom [TABLE_LEN];

  for (genvar k = 0; k < TABLE_LEN; k++) begin : g_coef
    localparam logic [63:0] QV =
      ((COEF_NUM[k] << FRAC_BITS) + COEF_DEN[k] / 2) / COEF_DEN[k];
    localparam logic [31:0] QS = (QV > 64'(W_MAX)) ? W_MAX : QV[31:0];
    assign coef_rom[k] = QS;
  end

  bkcf_state_t state, state_next;

  logic [15:0]        tolerance;
  logic [4:0]         max_terms;
  logic signed [31:0] v, v_next;
  logic [4:0]         lim, lim_next;
  logic [4:0]         used, used_next;
  logic signed [31:0] sum, sum_next;
  logic signed [31:0] del, del_next;
  logic signed [31:0] term, term_next;
  logic signed [31:0] tmp, tmp_next;
  logic signed [31:0] k_value_next;
  logic [4:0]         terms_used_next;
  logic               div_fault_next;

  logic               mul_start;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic               mul_done;
  logic signed [31:0] mul_q;
  logic               rcp_start;
  logic               rcp_done;
  logic signed [31:0] rcp_q;

  logic [4:0]         coef_idx;
  logic [31:0]        term_mag;

  assign coef_idx = used + 5'd1;
  assign term_mag = term[31] ? 32'(-term) : 32'(term);
  assign busy     = (state != ST_IDLE);
  assign done     = (state == ST_DONE);

  bkcf_qmul #(.FRAC_BITS(FRAC_BITS)) u_qmul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .q     (mul_q)
  );

  bkcf_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
    .clk   (clk),
    .rst   (rst),
    .start (rcp_start),
    .x     (tmp),
    .done  (rcp_done),
    .q     (rcp_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tolerance <= TOLERANCE_RESET;
      max_terms <= MAX_TERMS_RESET;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_TOLERANCE: tolerance <= cfg_data;
          REG_MAX_TERMS: max_terms <= cfg_data[4:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    v          <= v_next;
    lim        <= lim_next;
    used       <= used_next;
    sum        <= sum_next;
    del        <= del_next;
    term       <= term_next;
    tmp        <= tmp_next;
    k_value    <= k_value_next;
    terms_used <= terms_used_next;
    div_fault  <= div_fault_next;
  end

  always_comb begin
    state_next      = state;
    v_next          = v;
    lim_next        = lim;
    used_next       = used;
    sum_next        = sum;
    del_next        = del;
    term_next       = term;
    tmp_next        = tmp;
    k_value_next    = k_value;
    terms_used_next = terms_used;
    div_fault_next  = div_fault;
    mul_start       = 1'b0;
    mul_a           = '0;
    mul_b           = '0;
    rcp_start       = 1'b0;

    case (state)
      ST_IDLE: begin
        if (start) begin
          v_next    = arg_v;
          used_next = '0;
          sum_next  = coef_rom[0];
          term_next = coef_rom[0];
          del_next  = ONE;
          if (max_terms == '0) lim_next = 5'd1;
          else if (max_terms > LIM_MAX) lim_next = LIM_MAX;
          else lim_next = max_terms;
          state_next = ST_MUL_CV;
        end
      end
      ST_MUL_CV: begin
        mul_start  = 1'b1;
        mul_a      = coef_rom[coef_idx];
        mul_b      = v;
        state_next = ST_WAIT_CV;
      end
      ST_WAIT_CV: begin
        if (mul_done) begin
          tmp_next   = mul_q;
          state_next = ST_MUL_DEL;
        end
      end
      ST_MUL_DEL: begin
        mul_start  = 1'b1;
        mul_a      = tmp;
        mul_b      = del;
        state_next = ST_WAIT_DEL;
      end
      ST_WAIT_DEL: begin
        if (mul_done) begin
          tmp_next   = sat33(33'(ONE) + 33'(mul_q));
          state_next = ST_CHK_DEN;
        end
      end
      ST_CHK_DEN: begin
        used_next = used + 5'd1;
        if (tmp == '0) begin
          k_value_next    = W_MAX;
          terms_used_next = used + 5'd1;
          div_fault_next  = 1'b1;
          state_next      = ST_DONE;
        end else begin
          rcp_start  = 1'b1;
          state_next = ST_WAIT_RCP;
        end
      end
      ST_WAIT_RCP: begin
        if (rcp_done) begin
          del_next   = rcp_q;
          state_next = ST_SUB_ONE;
        end
      end
      ST_SUB_ONE: begin
        tmp_next   = sat33(33'(del) - 33'(ONE));
        state_next = ST_MUL_TERM;
      end
      ST_MUL_TERM: begin
        mul_start  = 1'b1;
        mul_a      = term;
        mul_b      = tmp;
        state_next = ST_WAIT_TERM;
      end
      ST_WAIT_TERM: begin
        if (mul_done) begin
          term_next  = mul_q;
          state_next = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        sum_next = sat33(33'(sum) + 33'(term));
        if (used >= lim || term_mag <= {16'd0, tolerance}) begin
          k_value_next    = sum_next;
          terms_used_next = used;
          div_fault_next  = 1'b0;
          state_next      = ST_DONE;
        end else begin
          state_next = ST_MUL_CV;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_fault_sat: assert property (@(posedge clk) disable iff (rst)
    (done && div_fault) |-> (k_value == W_MAX))
    else $error("zero denominator result not saturated");

  a_terms_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (terms_used != 5'd0 && terms_used <= lim))
    else $error("terms_used out of range");

  a_mul_done_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == ST_WAIT_CV || state == ST_WAIT_DEL || state == ST_WAIT_TERM))
    else $error("multiplier result arrived outside a wait state");

  a_rcp_done_wait: assert property (@(posedge clk) disable iff (rst)
    rcp_done |-> (state == ST_WAIT_RCP))
    else $error("reciprocal result arrived outside its wait state");

endmodule

>>> tb/bkcf_checker.sv
// Checker for the Battin K continued-fraction block: predicts each transaction and compares results.
module bkcf_checker
  import bkcf_pkg::*;
#(
  parameter int NUM_TERMS = 20,
  parameter int FRAC_BITS = 28
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] arg_v,
  input  logic               done,
  input  logic signed [31:0] k_value,
  input  logic [4:0]         terms_used,
  input  logic               div_fault,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);

  typedef logic signed [63:0] wide_t;

  typedef struct packed {
    logic signed [31:0] k_value;
    logic [4:0]         terms;
    logic               fault;
  } k_result_t;

  localparam wide_t WORD_MAX = W_MAX;
  localparam wide_t WORD_MIN = W_MIN;

  localparam int unsigned D_NUM [21] = '{
    1, 4, 8, 2, 22, 208, 340, 418, 598, 700, 928,
    1054, 1330, 1480, 1804, 1978, 2350, 2548, 2968, 3190, 3658
  };
  localparam int unsigned D_DEN [21] = '{
    3, 27, 27, 9, 81, 891, 1287, 1755, 2295, 2907, 3591,
    4347, 5175, 6075, 7047, 8091, 9207, 10395, 11655, 12987, 14391
  };

  logic [15:0] tol_q;
  logic [4:0]  limit_q;
  k_result_t   k_expected_q [$];
  k_result_t   want;

  function automatic wide_t clamp_word(wide_t x);
    if (x > WORD_MAX) return WORD_MAX;
    if (x < WORD_MIN) return WORD_MIN;
    return x;
  endfunction

  function automatic logic [63:0] magnitude(wide_t x);
    return (x < 0) ? 64'(-x) : 64'(x);
  endfunction

  function automatic wide_t coef_q(int k);
    logic [63:0] n;
    logic [63:0] q;
    n = (64'(D_NUM[k]) << FRAC_BITS) + 64'(D_DEN[k] / 2);
    q = n / 64'(D_DEN[k]);
    return (q > 64'h7FFF_FFFF) ? WORD_MAX : wide_t'(q);
  endfunction

  // round to nearest, halves away from zero
  function automatic wide_t fx_mul(wide_t a, wide_t b);
    logic        neg;
    logic [63:0] p;
    neg = (a < 0) != (b < 0);
    p = magnitude(a) * magnitude(b);
    p = (p + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (neg) return (p > 64'h8000_0000) ? WORD_MIN : -wide_t'(p);
    return (p > 64'h7FFF_FFFF) ? WORD_MAX : wide_t'(p);
  endfunction

  // magnitude truncated toward zero
  function automatic wide_t fx_recip(wide_t x);
    logic [63:0] q;
    q = (64'd1 << (2 * FRAC_BITS)) / magnitude(x);
    if (x < 0) return (q > 64'h7FFF_FFFF) ? WORD_MIN : -wide_t'(q);
    return (q > 64'h7FFF_FFFF) ? WORD_MAX : wide_t'(q);
  endfunction

  function automatic k_result_t predict_k(logic signed [31:0] v, logic [15:0] tol,
                                         logic [4:0] lim_raw);
    wide_t     one;
    wide_t     sum;
    wide_t     del;
    wide_t     term;
    wide_t     den;
    wide_t     v64;
    int        lim;
    int        k;
    k_result_t r;
    one = clamp_word(wide_t'(1) <<< FRAC_BITS);
    v64 = v;
    lim = lim_raw;
    if (lim < 1) lim = 1;
    if (lim > NUM_TERMS) lim = NUM_TERMS;
    if (lim > 20) lim = 20;
    sum = coef_q(0);
    del = one;
    term = sum;
    r.terms = '0;
    r.fault = 1'b0;
    for (k = 1; k <= lim; k++) begin
      r.terms = 5'(k);
      den = clamp_word(one + fx_mul(fx_mul(coef_q(k), v64), del));
      if (den == 0) begin
        r.fault = 1'b1;
        sum = WORD_MAX;
        break;
      end
      del = fx_recip(den);
      term = fx_mul(term, clamp_word(del - one));
      sum = clamp_word(sum + term);
      if (magnitude(term) <= 64'(tol)) break;
    end
    r.k_value = sum[31:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < 40) $display("[%0t] ERROR %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      tol_q = TOLERANCE_RESET;
      limit_q = MAX_TERMS_RESET;
      k_expected_q.delete();
    end else begin
      if (done) begin
        if (k_expected_q.size() == 0) begin
          report_mismatch($sformatf("result with no transaction pending: k_value=%h", k_value));
        end else begin
          want = k_expected_q.pop_front();
          if (k_value !== want.k_value)
            report_mismatch($sformatf("k_value %h, want %h", k_value, want.k_value));
          if (terms_used !== want.terms)
            report_mismatch($sformatf("terms_used %0d, want %0d", terms_used, want.terms));
          if (div_fault !== want.fault)
            report_mismatch($sformatf("div_fault %b, want %b", div_fault, want.fault));
        end
      end
      if (start && !busy) k_expected_q.push_back(predict_k(arg_v, tol_q, limit_q));
      if (cfg_we) begin
        case (cfg_index)
          REG_TOLERANCE: tol_q = cfg_data;
          REG_MAX_TERMS: limit_q = cfg_data[4:0];
          default: ;
        endcase
      end
    end
    pending = k_expected_q.size();
  end

endmodule

>>> tb/battin_k_continued_fraction_tb.sv
// Testbench top for the Battin K continued-fraction block: stimulus, register phases and verdict.
module battin_k_continued_fraction_tb;
  import bkcf_pkg::*;

  localparam int NUM_TERMS     = 20;
  localparam int FRAC_BITS     = 28;
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int DRAIN_CYCLES  = 1500;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 48;

  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;

  localparam logic signed [31:0] Q_ONE    = 32'sh1000_0000;
  localparam logic signed [31:0] POLE_ARG = -32'sd1811939314;

  localparam logic signed [31:0] EDGE_ARGS [16] = '{
    32'sd0, 32'sd1, -32'sd1, W_MAX, W_MIN, Q_ONE, -Q_ONE, 32'sh0800_0000,
    -32'sh0800_0000, 32'sh2000_0000, -32'sh4000_0000, POLE_ARG, POLE_ARG + 32'sd2,
    -32'sd1811939328, 32'sh5555_5555, 32'shAAAA_AAAA
  };

  logic               clk;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] arg_v = '0;
  logic               done;
  logic signed [31:0] k_value;
  logic [4:0]         terms_used;
  logic               div_fault;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  int                 fail_count;
  int                 pending;
  int                 cycle_count;
  int                 idle_pct;

  battin_k_continued_fraction #(
    .NUM_TERMS(NUM_TERMS),
    .FRAC_BITS(FRAC_BITS)
  ) uut (.*);

  bkcf_checker #(
    .NUM_TERMS(NUM_TERMS),
    .FRAC_BITS(FRAC_BITS)
  ) result_check (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("battin_k_continued_fraction: mismatch");
      $finish;
    end
  end

  // hold start until the block takes the transaction; returns on a falling edge
  task automatic send_arg(input logic signed [31:0] v);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    arg_v <= v;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_arg();
    int unsigned        pick;
    logic signed [31:0] r;
    pick = $urandom_range(99);
    if (pick < 45) begin
      r = $urandom;
    end else if (pick < 75) begin
      r = 32'($urandom_range(32'h4000_0000)) - 32'sh2000_0000;
    end else if (pick < 87) begin
      r = POLE_ARG + 32'($urandom_range(64)) - 32'sd32;
    end else if (pick[0]) begin
      r = W_MAX - 32'($urandom_range(4095));
    end else begin
      r = W_MIN + 32'($urandom_range(4095));
    end
    return r;
  endfunction

  initial begin
    int          p;
    int          n;
    logic [15:0] tol;
    logic [15:0] lim;
    idle_pct = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (EDGE_ARGS[i]) send_arg(EDGE_ARGS[i]);

    settle();
    write_reg(REG_SPARE_A, 16'hFFFF);
    write_reg(REG_SPARE_B, 16'h0000);
    send_arg(Q_ONE);
    settle();
    write_reg(REG_MAX_TERMS, 16'h0000);
    send_arg(32'sh0800_0000);
    settle();
    write_reg(REG_TOLERANCE, 16'h0000);
    write_reg(REG_MAX_TERMS, 16'h003F);
    send_arg(32'sh0400_0000);
    settle();
    write_reg(REG_TOLERANCE, 16'hFFFF);
    write_reg(REG_MAX_TERMS, 16'd20);
    send_arg(32'sh1800_0000);
    settle();
    write_reg(REG_TOLERANCE, 16'h0000);
    write_reg(REG_MAX_TERMS, 16'hFFE1);
    send_arg(W_MIN);

    for (p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      case (p % 4)
        0: idle_pct = 0;
        1: idle_pct = 61;
        2: idle_pct = 0;
        default: idle_pct = 11;
      endcase
      case (p)
        0: begin
          tol = TOLERANCE_RESET;
          lim = 16'd20;
        end
        1: begin
          tol = 16'd0;
          lim = 16'd12;
        end
        2: begin
          tol = 16'hFFFF;
          lim = 16'hFFFF;
        end
        3: begin
          tol = 16'($urandom);
          lim = 16'($urandom_range(1, 20));
        end
        4: begin
          tol = 16'd0;
          lim = 16'd0;
        end
        5: begin
          tol = 16'($urandom_range(1000));
          lim = 16'($urandom);
        end
        6: begin
          tol = 16'($urandom_range(300));
          lim = 16'd1;
        end
        default: begin
          tol = 16'($urandom);
          lim = 16'($urandom_range(2, 20));
        end
      endcase
      write_reg(REG_TOLERANCE, tol);
      write_reg(REG_MAX_TERMS, lim);
      for (n = 0; n < PHASE_ITEMS; n++) send_arg(rand_arg());
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("battin_k_continued_fraction: match");
    end else begin
      $display("battin_k_continued_fraction: mismatch");
    end
    $finish;
  end

endmodule
